// ===== src/touch_coordinate_calibrator_macros.svh =====
// assertion macros for the touch coordinate calibrator
// used by the top level, expects clk_i and rst_ni in scope
`ifndef TOUCH_COORDINATE_CALIBRATOR_MACROS_SVH
`define TOUCH_COORDINATE_CALIBRATOR_MACROS_SVH

// same-cycle implication, held off during reset
`define TCC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("touch calibrator check failed");

// next-cycle implication, held off during reset
`define TCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("touch calibrator check failed");

`endif

// ===== src/tcc_pkg.sv =====
// shared types and constants of the touch coordinate calibrator
// no dependencies
package tcc_pkg;

  localparam int unsigned CoordW = 10;
  localparam int unsigned SumW   = 13;
  localparam int unsigned CountW = 16;
  localparam int unsigned NumW   = 2 * CoordW;

  // default touch window
  localparam logic [CoordW-1:0] DefXLow  = 10'd200;
  localparam logic [CoordW-1:0] DefXHigh = 10'd750;
  localparam logic [CoordW-1:0] DefYLow  = 10'd120;
  localparam logic [CoordW-1:0] DefYHigh = 10'd620;

  // ceil(2^16 / 5), exact floor(sum / 5) for any 13-bit sum
  localparam logic [13:0] Recip5 = 14'd13108;
  localparam int unsigned RecipShift = 16;

  // index of the divider's last step
  localparam logic [3:0] DivLastStep = 4'd9;

  typedef struct packed {
    logic load;
    logic avg;
    logic prep;
    logic div_start;
    logic commit;
  } tcc_cmd_t;

  typedef struct packed {
    logic div_done;
  } tcc_status_t;

endpackage

// ===== src/touch_coordinate_calibrator.sv =====
// touch coordinate calibrator: averaging, window scaling and two-touch calibration
// one word in flight: the next word is taken only after the last one is committed,
// and the commit waits while the output register is held
// scaling uses the 10-step restoring dividers, one per axis, run in parallel
// reset (async, active low) restores the default window, ends calibration, clears count
// depends on tcc_pkg, tcc_ctrl, tcc_dp, tcc_div and the assertion macro header
`include "touch_coordinate_calibrator_macros.svh"

module touch_coordinate_calibrator #(
  parameter int unsigned SCREEN_WIDTH  = 320,
  parameter int unsigned SCREEN_HEIGHT = 240
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input word
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       req_type_i,
  input  logic [tcc_pkg::CoordW-1:0] x_sample_0_i,
  input  logic [tcc_pkg::CoordW-1:0] x_sample_1_i,
  input  logic [tcc_pkg::CoordW-1:0] x_sample_2_i,
  input  logic [tcc_pkg::CoordW-1:0] x_sample_3_i,
  input  logic [tcc_pkg::CoordW-1:0] x_sample_4_i,
  input  logic [tcc_pkg::CoordW-1:0] y_sample_0_i,
  input  logic [tcc_pkg::CoordW-1:0] y_sample_1_i,
  input  logic [tcc_pkg::CoordW-1:0] y_sample_2_i,
  input  logic [tcc_pkg::CoordW-1:0] y_sample_3_i,
  input  logic [tcc_pkg::CoordW-1:0] y_sample_4_i,
  // result word
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [tcc_pkg::CoordW-1:0] pos_x_o,
  output logic [tcc_pkg::CoordW-1:0] pos_y_o,
  output logic                       in_window_o,
  output logic                       calibrating_o,
  output logic [tcc_pkg::CountW-1:0] touch_total_o
);
  import tcc_pkg::*;

  // command and status between sequencer and datapath
  tcc_cmd_t    cmd;
  tcc_status_t status;

  // sequencer: accept, average, window check, divide, then commit into
  // the output register once it is free
  tcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  // datapath: holds the window, calibration corner, touch count and result word
  tcc_dp #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .req_type_i   (req_type_i),
    .x_sample_0_i (x_sample_0_i),
    .x_sample_1_i (x_sample_1_i),
    .x_sample_2_i (x_sample_2_i),
    .x_sample_3_i (x_sample_3_i),
    .x_sample_4_i (x_sample_4_i),
    .y_sample_0_i (y_sample_0_i),
    .y_sample_1_i (y_sample_1_i),
    .y_sample_2_i (y_sample_2_i),
    .y_sample_3_i (y_sample_3_i),
    .y_sample_4_i (y_sample_4_i),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o),
    .in_window_o  (in_window_o),
    .calibrating_o(calibrating_o),
    .touch_total_o(touch_total_o)
  );

  // a scaled position only happens outside calibration and stays on screen
  `TCC_ASSERT_NOW(a_scaled_not_cal, out_valid_o && in_window_o, !calibrating_o)
  `TCC_ASSERT_NOW(a_scaled_range, out_valid_o && in_window_o,
    (32'(pos_x_o) <= SCREEN_WIDTH) && (32'(pos_y_o) <= SCREEN_HEIGHT))
  // one word at a time: no second accept right behind the first
  `TCC_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o)

endmodule

// ===== src/tcc_div.sv =====
// restoring divider, one quotient bit per cycle, 10-bit quotient
// depends on tcc_pkg
module tcc_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tcc_pkg::NumW-1:0]   num_i,
  input  logic [tcc_pkg::CoordW-1:0] den_i,
  output logic                       done_o,
  output logic [tcc_pkg::CoordW-1:0] quo_o
);
  import tcc_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [3:0]        cnt_q, cnt_d;
  logic [CoordW-1:0] rem_q, rem_d;
  logic [CoordW-1:0] lo_q, lo_d;
  logic [CoordW:0]   trial;
  logic              ge;

  // quotient fits in 10 bits, so the upper half already sits below the divisor
  assign trial = {rem_q, lo_q[CoordW-1]};
  assign ge    = trial >= {1'b0, den_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    lo_d   = lo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = num_i[NumW-1:CoordW];
      lo_d   = num_i[CoordW-1:0];
    end else if (busy_q) begin
      rem_d = ge ? CoordW'(trial - {1'b0, den_i}) : trial[CoordW-1:0];
      lo_d  = {lo_q[CoordW-2:0], ge};
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == DivLastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
  end

  assign done_o = done_q;
  assign quo_o  = lo_q;

endmodule

// ===== src/tcc_ctrl.sv =====
// sequencing state machine and output word valid flag
// depends on tcc_pkg
module tcc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tcc_pkg::tcc_cmd_t    cmd_o,
  input  tcc_pkg::tcc_status_t status_i
);
  import tcc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_AVG   = 6'b000010,
    S_PREP  = 6'b000100,
    S_START = 6'b001000,
    S_DIV   = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_AVG;
        end
      end
      S_AVG: begin
        cmd_o.avg = 1'b1;
        state_d   = S_PREP;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_START;
      end
      S_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (status_i.div_done) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit)     out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== src/tcc_dp.sv =====
// datapath: averaging, window check, scaling dividers, calibration state, output word
// depends on tcc_pkg and tcc_div
module tcc_dp #(
  parameter int unsigned SCREEN_WIDTH  = 320,
  parameter int unsigned SCREEN_HEIGHT = 240
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tcc_pkg::tcc_cmd_t          cmd_i,
  output tcc_pkg::tcc_status_t       status_o,
  input  logic                       req_type_i,
  input  logic [tcc_pkg::CoordW-1:0] x_sample_0_i,
  input  logic [tcc_pkg::CoordW-1:0] x_sample_1_i,
  input  logic [tcc_pkg::CoordW-1:0] x_sample_2_i,
  input  logic [tcc_pkg::CoordW-1:0] x_sample_3_i,
  input  logic [tcc_pkg::CoordW-1:0] x_sample_4_i,
  input  logic [tcc_pkg::CoordW-1:0] y_sample_0_i,
  input  logic [tcc_pkg::CoordW-1:0] y_sample_1_i,
  input  logic [tcc_pkg::CoordW-1:0] y_sample_2_i,
  input  logic [tcc_pkg::CoordW-1:0] y_sample_3_i,
  input  logic [tcc_pkg::CoordW-1:0] y_sample_4_i,
  output logic [tcc_pkg::CoordW-1:0] pos_x_o,
  output logic [tcc_pkg::CoordW-1:0] pos_y_o,
  output logic                       in_window_o,
  output logic                       calibrating_o,
  output logic [tcc_pkg::CountW-1:0] touch_total_o
);
  import tcc_pkg::*;

  localparam logic [CoordW-1:0] FullX = CoordW'(SCREEN_WIDTH);
  localparam logic [CoordW-1:0] FullY = CoordW'(SCREEN_HEIGHT);
  localparam int unsigned ProdW = SumW + 14;

  // per-item working registers
  logic              req_q;
  logic [SumW-1:0]   sum_x_q, sum_y_q;
  logic [CoordW-1:0] ax_q, ay_q;
  logic              win_hit_q;
  logic [NumW-1:0]   num_x_q, num_y_q;
  logic [CoordW-1:0] span_x_q, span_y_q;

  // persistent state
  logic [CoordW-1:0] xlo_q, xhi_q, ylo_q, yhi_q;
  logic              cal_q, held_q;
  logic [CoordW-1:0] corner_x_q, corner_y_q;
  logic [CountW-1:0] count_q;
  logic [CoordW-1:0] last_x_q, last_y_q;

  // output word
  logic [CoordW-1:0] pos_x_q, pos_y_q;
  logic              in_win_q, cal_out_q;
  logic [CountW-1:0] total_q;

  logic [SumW-1:0]   sum_x, sum_y;
  logic [ProdW-1:0]  prod_x, prod_y;
  logic              win_hit;
  logic              done_x, done_y;
  logic [CoordW-1:0] quo_x, quo_y;
  logic [CoordW-1:0] px, py;
  logic [CountW-1:0] count_inc;

  assign sum_x = SumW'(x_sample_0_i) + SumW'(x_sample_1_i) + SumW'(x_sample_2_i)
               + SumW'(x_sample_3_i) + SumW'(x_sample_4_i);
  assign sum_y = SumW'(y_sample_0_i) + SumW'(y_sample_1_i) + SumW'(y_sample_2_i)
               + SumW'(y_sample_3_i) + SumW'(y_sample_4_i);

  // divide by five through the reciprocal
  assign prod_x = ProdW'(sum_x_q) * ProdW'(Recip5);
  assign prod_y = ProdW'(sum_y_q) * ProdW'(Recip5);

  assign win_hit = !cal_q && (ax_q >= xlo_q) && (ax_q <= xhi_q)
                          && (ay_q >= ylo_q) && (ay_q <= yhi_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= req_type_i;
      sum_x_q <= sum_x;
      sum_y_q <= sum_y;
    end
    if (cmd_i.avg) begin
      ax_q <= prod_x[RecipShift +: CoordW];
      ay_q <= prod_y[RecipShift +: CoordW];
    end
    if (cmd_i.prep) begin
      win_hit_q <= win_hit;
      num_x_q   <= NumW'(FullX) * NumW'(CoordW'(ax_q - xlo_q));
      num_y_q   <= NumW'(FullY) * NumW'(CoordW'(ay_q - ylo_q));
      span_x_q  <= xhi_q - xlo_q;
      span_y_q  <= yhi_q - ylo_q;
    end
  end

  tcc_div u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (num_x_q),
    .den_i  (span_x_q),
    .done_o (done_x),
    .quo_o  (quo_x)
  );

  tcc_div u_div_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (num_y_q),
    .den_i  (span_y_q),
    .done_o (done_y),
    .quo_o  (quo_y)
  );

  // both dividers run in lockstep
  assign status_o.div_done = done_x & done_y;

  // zero span scales to the origin
  always_comb begin
    px = ax_q;
    py = ay_q;
    if (win_hit_q) begin
      px = (span_x_q == '0) ? '0 : quo_x;
      py = (span_y_q == '0) ? '0 : quo_y;
    end
  end

  assign count_inc = count_q + CountW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xlo_q    <= DefXLow;
      xhi_q    <= DefXHigh;
      ylo_q    <= DefYLow;
      yhi_q    <= DefYHigh;
      cal_q    <= 1'b0;
      held_q   <= 1'b0;
      count_q  <= '0;
      last_x_q <= '0;
      last_y_q <= '0;
    end else if (cmd_i.commit) begin
      if (req_q) begin
        xlo_q  <= DefXLow;
        xhi_q  <= DefXHigh;
        ylo_q  <= DefYLow;
        yhi_q  <= DefYHigh;
        held_q <= 1'b0;
        cal_q  <= 1'b1;
      end else begin
        if (cal_q && held_q) begin
          xlo_q  <= (px < corner_x_q) ? px : corner_x_q;
          xhi_q  <= (px < corner_x_q) ? corner_x_q : px;
          ylo_q  <= (py < corner_y_q) ? py : corner_y_q;
          yhi_q  <= (py < corner_y_q) ? corner_y_q : py;
          held_q <= 1'b0;
          cal_q  <= 1'b0;
        end else if (cal_q) begin
          held_q <= 1'b1;
        end
        count_q  <= count_inc;
        last_x_q <= px;
        last_y_q <= py;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && !req_q && cal_q && !held_q) begin
      corner_x_q <= px;
      corner_y_q <= py;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (req_q) begin
        pos_x_q   <= last_x_q;
        pos_y_q   <= last_y_q;
        in_win_q  <= 1'b0;
        cal_out_q <= 1'b1;
        total_q   <= count_q;
      end else begin
        pos_x_q   <= px;
        pos_y_q   <= py;
        in_win_q  <= win_hit_q;
        cal_out_q <= cal_q && !held_q;
        total_q   <= count_inc;
      end
    end
  end

  assign pos_x_o       = pos_x_q;
  assign pos_y_o       = pos_y_q;
  assign in_window_o   = in_win_q;
  assign calibrating_o = cal_out_q;
  assign touch_total_o = total_q;

endmodule
